// ===== hdl/refcounted_id_slot_allocator_core_assert.svh =====
// assertion macros for the refcounted identifier slot allocator
// expects clk and arst_n in the scope of each use
`ifndef REFCOUNTED_ID_SLOT_ALLOCATOR_CORE_ASSERT_SVH
`define REFCOUNTED_ID_SLOT_ALLOCATOR_CORE_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication, disabled during reset
`define RCSA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication, disabled during reset
`define RCSA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define RCSA_ASSERT_IMP(lbl, ante, cons, msg)
`define RCSA_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hdl/rcsa_pkg.sv =====
// shared types and constants for the refcounted identifier slot allocator
// no dependencies
`timescale 1ns / 1ps

package rcsa_pkg;

	localparam int ENTRIES     = 16;
	localparam int COUNT_WIDTH = 16;
	localparam int IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int KEY_W       = 64;
	localparam int OP_W        = 2;
	localparam int SLOT_W      = 4;
	localparam int OUT_CNT_W   = 16;
	localparam int STATUS_W    = 2;

	localparam logic [OP_W-1:0] OP_REGISTER   = 2'd0;
	localparam logic [OP_W-1:0] OP_UNREGISTER = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY      = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
	localparam logic [STATUS_W-1:0] ST_UNKNOWN   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_SATURATED = 2'd3;

	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
	localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

	typedef struct packed {
		logic [KEY_W-1:0]       key;
		logic [COUNT_WIDTH-1:0] cnt;
	} ent_t;

	localparam int ENT_W = $bits(ent_t);

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		ent_t             wdata;
		logic             re;
		logic [IDX_W-1:0] raddr;
	} mem_req_t;

	typedef struct packed {
		logic [SLOT_W-1:0]    slot;
		logic                 held;
		logic [OUT_CNT_W-1:0] refcnt;
		logic [STATUS_W-1:0]  status;
	} res_t;

endpackage

// ===== hdl/rcsa_ram.sv =====
// generic single-write, single-read synchronous ram, registered read data
// no dependencies
`timescale 1ns / 1ps

module rcsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/rcsa_seq.sv =====
// request sequencer: scans the slot ram, tracks match and free slot, commits the update
// depends on rcsa_pkg
`timescale 1ns / 1ps

module rcsa_seq (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_ready,
	input  logic [rcsa_pkg::OP_W-1:0]         req_op,
	input  logic [rcsa_pkg::KEY_W-1:0]        req_ident,
	output rcsa_pkg::mem_req_t                mem,
	input  logic [rcsa_pkg::ENT_W-1:0]        mem_rdata,
	output logic                              res_valid,
	input  logic                              res_ready,
	output rcsa_pkg::res_t                    res
);
	import rcsa_pkg::*;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SCAN   = 2'd1;
	localparam logic [1:0] S_DECIDE = 2'd2;

	localparam logic [IDX_W:0]   CNT_END  = (IDX_W+1)'(ENTRIES);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);

	logic [1:0]             state_q;
	logic [OP_W-1:0]        op_q;
	logic [KEY_W-1:0]       ident_q;
	logic [IDX_W:0]         rd_cnt_q;
	logic                   cmp_vld_s1;
	logic [IDX_W-1:0]       cmp_idx_s1;
	logic [ENTRIES-1:0]     used_q;
	logic                   hit_q;
	logic [IDX_W-1:0]       hit_idx_q;
	logic [COUNT_WIDTH-1:0] hit_cnt_q;
	logic                   free_q;
	logic [IDX_W-1:0]       free_idx_q;

	ent_t                   rd_ent;
	logic                   issue;
	logic                   cmp_used;
	logic                   cmp_hit;
	logic                   cmp_free;
	logic                   last_cmp;
	logic                   commit;
	logic                   wr_en;
	logic [IDX_W-1:0]       wr_idx;
	logic [COUNT_WIDTH-1:0] wr_cnt;
	logic                   set_used;
	logic                   clr_used;

	assign rd_ent    = ent_t'(mem_rdata);
	assign req_ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DECIDE);
	assign commit    = res_valid && res_ready;

	assign issue    = (state_q == S_SCAN) && (rd_cnt_q < CNT_END);
	assign cmp_used = used_q[cmp_idx_s1];
	assign cmp_hit  = cmp_vld_s1 && cmp_used && (rd_ent.key == ident_q);
	assign cmp_free = cmp_vld_s1 && !cmp_used;
	assign last_cmp = cmp_vld_s1 && (cmp_idx_s1 == IDX_LAST);

	always_comb begin
		mem.re          = issue;
		mem.raddr       = rd_cnt_q[IDX_W-1:0];
		mem.we          = wr_en && commit;
		mem.waddr       = wr_idx;
		mem.wdata.key   = ident_q;
		mem.wdata.cnt   = wr_cnt;
	end

	// outcome of the request from the scan summary
	always_comb begin
		res       = '0;
		wr_en     = 1'b0;
		wr_idx    = hit_idx_q;
		wr_cnt    = hit_cnt_q;
		set_used  = 1'b0;
		clr_used  = 1'b0;
		case (op_q)
			OP_REGISTER: begin
				if (hit_q) begin
					res.slot = SLOT_W'(hit_idx_q);
					res.held = 1'b1;
					if (hit_cnt_q == CNT_MAX) begin
						res.refcnt = OUT_CNT_W'(hit_cnt_q);
						res.status = ST_SATURATED;
					end else begin
						wr_en      = 1'b1;
						wr_cnt     = hit_cnt_q + CNT_ONE;
						res.refcnt = OUT_CNT_W'(wr_cnt);
						res.status = ST_OK;
					end
				end else if (free_q) begin
					wr_en      = 1'b1;
					wr_idx     = free_idx_q;
					wr_cnt     = CNT_ONE;
					set_used   = 1'b1;
					res.slot   = SLOT_W'(free_idx_q);
					res.held   = 1'b1;
					res.refcnt = OUT_CNT_W'(CNT_ONE);
					res.status = ST_OK;
				end else begin
					res.status = ST_FULL;
				end
			end
			OP_UNREGISTER: begin
				if (!hit_q) begin
					res.status = ST_UNKNOWN;
				end else if (hit_cnt_q <= CNT_ONE) begin
					clr_used   = 1'b1;
					res.status = ST_OK;
				end else begin
					wr_en      = 1'b1;
					wr_cnt     = hit_cnt_q - CNT_ONE;
					res.slot   = SLOT_W'(hit_idx_q);
					res.held   = 1'b1;
					res.refcnt = OUT_CNT_W'(wr_cnt);
					res.status = ST_OK;
				end
			end
			default: begin
				if (hit_q) begin
					res.slot   = SLOT_W'(hit_idx_q);
					res.held   = 1'b1;
					res.refcnt = OUT_CNT_W'(hit_cnt_q);
					res.status = ST_OK;
				end else begin
					res.status = ST_UNKNOWN;
				end
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			rd_cnt_q   <= '0;
			cmp_vld_s1 <= 1'b0;
			hit_q      <= 1'b0;
			free_q     <= 1'b0;
			used_q     <= '0;
		end else begin
			cmp_vld_s1 <= issue;
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q  <= S_SCAN;
						rd_cnt_q <= '0;
						hit_q    <= 1'b0;
						free_q   <= 1'b0;
					end
				end
				S_SCAN: begin
					if (issue) begin
						rd_cnt_q <= rd_cnt_q + 1'b1;
					end
					if (cmp_hit) begin
						hit_q <= 1'b1;
					end
					if (cmp_free) begin
						free_q <= 1'b1;
					end
					if (last_cmp) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (commit) begin
						state_q <= S_IDLE;
						if (set_used) begin
							used_q[free_idx_q] <= 1'b1;
						end
						if (clr_used) begin
							used_q[hit_idx_q] <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request and scan payload
	always_ff @(posedge clk) begin
		cmp_idx_s1 <= rd_cnt_q[IDX_W-1:0];
		if (req_valid && req_ready) begin
			op_q    <= req_op;
			ident_q <= req_ident;
		end
		// first match and first free slot win
		if (cmp_hit && !hit_q) begin
			hit_idx_q <= cmp_idx_s1;
			hit_cnt_q <= rd_ent.cnt;
		end
		if (cmp_free && !free_q) begin
			free_idx_q <= cmp_idx_s1;
		end
	end

endmodule

// ===== hdl/refcounted_id_slot_allocator_core.sv =====
// each request is scanned slot by slot, then decided and committed to the output register
// a new request is taken only after the last one commits; the scan reads one slot a cycle
// the scan is one read per slot through the single ram read port, then the commit in decide
// the output register holds a result while the next request is taken in
// reset: arst_n clears all slot-used bits, the sequencer and the output valid; ram holds junk
`timescale 1ns / 1ps

`include "refcounted_id_slot_allocator_core_assert.svh"

module refcounted_id_slot_allocator_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [rcsa_pkg::OP_W-1:0]           opcode,
	input  logic [rcsa_pkg::KEY_W-1:0]          ident,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [rcsa_pkg::SLOT_W-1:0]         slot,
	output logic                                held,
	output logic [rcsa_pkg::OUT_CNT_W-1:0]      refcnt,
	output logic [rcsa_pkg::STATUS_W-1:0]       status
);
	import rcsa_pkg::*;

	// sequencer to ram
	mem_req_t         mem;
	logic [ENT_W-1:0] mem_rdata;

	// sequencer to output register
	logic res_valid;
	logic res_ready;
	res_t res;

	// output register
	logic out_valid_q;
	res_t out_q;

	// slot table: key and count per slot, one read and one write a cycle
	rcsa_ram #(
		.WIDTH (ENT_W),
		.DEPTH (ENTRIES),
		.AW    (IDX_W)
	) u_ram (
		.clk   (clk),
		.we    (mem.we),
		.waddr (mem.waddr),
		.wdata (mem.wdata),
		.re    (mem.re),
		.raddr (mem.raddr),
		.rdata (mem_rdata)
	);

	// scan, decide and commit; the only writer of the table so no overlap of accesses
	rcsa_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (in_valid),
		.req_ready (in_ready),
		.req_op    (opcode),
		.req_ident (ident),
		.mem       (mem),
		.mem_rdata (mem_rdata),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// commit only when the output slot is free or being emptied this cycle
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign slot      = out_q.slot;
	assign held      = out_q.held;
	assign refcnt    = out_q.refcnt;
	assign status    = out_q.status;

	// a full table never reports a slot
	`RCSA_ASSERT_IMP(a_full_empty, out_valid && (status == ST_FULL), !held && (slot == '0) && (refcnt == '0), "full result carries a slot")
	// a released or unknown identifier reports no count
	`RCSA_ASSERT_IMP(a_unheld_zero, out_valid && !held, (refcnt == '0) && (slot == '0), "unheld result carries a count")
	// a saturated count is held at its ceiling
	`RCSA_ASSERT_IMP(a_sat_held, out_valid && (status == ST_SATURATED), held && (refcnt == OUT_CNT_W'(CNT_MAX)), "saturated result below ceiling")
	// an accepted request keeps the block busy for its scan
	`RCSA_ASSERT_NXT(a_busy_after_req, in_valid && in_ready, !in_ready, "request taken during scan")

endmodule

// ===== tb/tb.sv =====
// self-checking testbench for refcounted_id_slot_allocator_core
// needs rcsa_pkg and the core rtl; a ledger class mirrors the slot table and checks results
`timescale 1ns / 1ps

module tb;
	import rcsa_pkg::*;

	// opcode three is decoded as a query by the core
	localparam logic [OP_W-1:0] OP_QUERY_ALT = 2'd3;

	localparam int RANDOM_ITEMS = 1870;
	localparam int BLOCK_ITEMS  = 120;
	localparam int POOL_SIZE    = 20;
	localparam int HOLD_AT      = 300;
	localparam int HOLD_CYCLES  = 500;
	localparam int DRAIN_CYCLES = 60;
	localparam int CYCLE_LIMIT  = 4000000;

	// mirror of the slot table plus the queue of results still owed by the core
	class slot_ledger;
		logic [KEY_W-1:0]       key_of[ENTRIES];
		bit                     used[ENTRIES];
		logic [COUNT_WIDTH-1:0] count_of[ENTRIES];
		res_t                   owed[$];
		int                     mismatches;
		int unsigned            results_seen;

		function new();
			foreach (used[i]) begin
				used[i]     = 1'b0;
				key_of[i]   = '0;
				count_of[i] = '0;
			end
			mismatches   = 0;
			results_seen = 0;
		endfunction

		// lowest used slot holding id, or -1
		function int lookup(logic [KEY_W-1:0] id);
			for (int i = 0; i < ENTRIES; i++)
				if (used[i] && key_of[i] == id)
					return i;
			return -1;
		endfunction

		function int lowest_free();
			for (int i = 0; i < ENTRIES; i++)
				if (!used[i])
					return i;
			return -1;
		endfunction

		// random key that currently holds a slot, 0 if the table is empty
		function bit pick_held(output logic [KEY_W-1:0] id);
			int taken[$];
			id = '0;
			for (int i = 0; i < ENTRIES; i++)
				if (used[i])
					taken.push_back(i);
			if (taken.size() == 0)
				return 1'b0;
			id = key_of[taken[$urandom_range(0, taken.size() - 1)]];
			return 1'b1;
		endfunction

		function res_t outcome(int idx, logic [STATUS_W-1:0] st);
			res_t r;
			r = '0;
			if (idx >= 0) begin
				r.slot   = SLOT_W'(idx);
				r.held   = 1'b1;
				r.refcnt = OUT_CNT_W'(count_of[idx]);
			end
			r.status = st;
			return r;
		endfunction

		// update the mirror for one accepted request and queue its result
		function void note_request(logic [OP_W-1:0] op, logic [KEY_W-1:0] id);
			int   idx;
			int   fr;
			res_t r;
			idx = lookup(id);
			case (op)
				OP_REGISTER: begin
					if (idx >= 0) begin
						if (count_of[idx] == CNT_MAX) begin
							r = outcome(idx, ST_SATURATED);
						end else begin
							count_of[idx] = count_of[idx] + 1'b1;
							r = outcome(idx, ST_OK);
						end
					end else begin
						fr = lowest_free();
						if (fr < 0) begin
							r = outcome(-1, ST_FULL);
						end else begin
							used[fr]     = 1'b1;
							key_of[fr]   = id;
							count_of[fr] = CNT_ONE;
							r = outcome(fr, ST_OK);
						end
					end
				end
				OP_UNREGISTER: begin
					if (idx < 0) begin
						r = outcome(-1, ST_UNKNOWN);
					end else if (count_of[idx] <= CNT_ONE) begin
						used[idx]     = 1'b0;
						count_of[idx] = '0;
						r = outcome(-1, ST_OK);
					end else begin
						count_of[idx] = count_of[idx] - 1'b1;
						r = outcome(idx, ST_OK);
					end
				end
				default: begin
					r = outcome(idx, (idx >= 0) ? ST_OK : ST_UNKNOWN);
				end
			endcase
			owed.push_back(r);
		endfunction

		function void compare_field(string name, longint unsigned want, longint unsigned got);
			if (want != got) begin
				$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
				mismatches++;
			end
		endfunction

		function void check_result(res_t got);
			res_t want;
			results_seen++;
			if (owed.size() == 0) begin
				$display("%0t: unexpected result, expected none actual slot %0d held %0d",
					$time, got.slot, got.held);
				$display("%0t: unexpected result count %0d status %0d",
					$time, got.refcnt, got.status);
				mismatches++;
				return;
			end
			want = owed.pop_front();
			compare_field("slot", want.slot, got.slot);
			compare_field("held", want.held, got.held);
			compare_field("refcnt", want.refcnt, got.refcnt);
			compare_field("status", want.status, got.status);
		endfunction
	endclass

	// clock, reset and block ports; the driven ones are known from time zero
	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	logic [OP_W-1:0]      opcode    = OP_QUERY;
	logic [KEY_W-1:0]     ident     = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [SLOT_W-1:0]    slot;
	logic                 held;
	logic [OUT_CNT_W-1:0] refcnt;
	logic [STATUS_W-1:0]  status;

	slot_ledger       ledger;
	bit               steady = 1'b0;   // when set neither side idles
	int               cycle_count = 0;
	logic [KEY_W-1:0] id_pool[POOL_SIZE];

	always #6 clk = ~clk;

	refcounted_id_slot_allocator_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.ident     (ident),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.slot      (slot),
		.held      (held),
		.refcnt    (refcnt),
		.status    (status)
	);

	// watchdog on total run length
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// offer one request; called at a rising edge, returns at the edge it is taken
	// valid is only lowered when a gap is drawn, so back-to-back requests keep it high
	task automatic send_request(logic [OP_W-1:0] op, logic [KEY_W-1:0] id);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode   <= op;
		ident    <= id;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		ledger.note_request(op, id);
	endtask

	// result side: random stalls, one long hold-off to back the core up into its input
	initial begin
		int gap;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (ledger.results_seen == HOLD_AT)
				gap = HOLD_CYCLES;
			else
				gap = steady ? 0 : $urandom_range(0, 9);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			ledger.check_result(res_t'({slot, held, refcnt, status}));
		end
	end

	// request side and end of run
	initial begin
		logic [KEY_W-1:0] id;
		logic [KEY_W-1:0] target;
		logic [OP_W-1:0]  op;
		int               r;
		int               pick;
		bit               draining;

		ledger = new();
		// pool a bit larger than the table so fill phases hit the full case
		id_pool[0] = '0;
		id_pool[1] = '1;
		for (int i = 2; i < POOL_SIZE; i++)
			id_pool[i] = {$urandom, $urandom};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty-table misses, register/count up/down, free, alias query
		send_request(OP_QUERY, '0);
		send_request(OP_UNREGISTER, '1);
		send_request(OP_REGISTER, '0);
		send_request(OP_REGISTER, '1);
		send_request(OP_REGISTER, '0);
		send_request(OP_QUERY, '1);
		send_request(OP_QUERY_ALT, '0);
		send_request(OP_UNREGISTER, '0);
		send_request(OP_UNREGISTER, '0);     // count reaches zero, slot freed
		send_request(OP_QUERY, '0);
		// fill the remaining fifteen slots, then overflow
		for (int k = 0; k < ENTRIES - 1; k++)
			send_request(OP_REGISTER, KEY_W'(1) << (4 * k + 3));
		send_request(OP_REGISTER, 64'hdead_beef_0bad_f00d);
		// a freed slot in the middle is the next one claimed
		send_request(OP_UNREGISTER, '1);
		send_request(OP_REGISTER, 64'h5a5a_a5a5_3c3c_c3c3);

		// random: alternating fill-biased and drain-biased blocks, every fourth block gapless
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			steady   = ((n / BLOCK_ITEMS) % 4) == 3;
			draining = ((n / BLOCK_ITEMS) % 2) == 1;
			r = $urandom_range(0, 99);
			if (r < (draining ? 25 : 55))
				op = OP_REGISTER;
			else if (r < 75)
				op = OP_UNREGISTER;
			else if (r < 92)
				op = OP_QUERY;
			else
				op = OP_QUERY_ALT;
			pick = $urandom_range(0, 99);
			if (op == OP_UNREGISTER && pick < 70 && ledger.pick_held(id))
				; // unregister a key that is actually held
			else if (pick < 88)
				id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
			else
				id = {$urandom, $urandom};   // almost surely unknown
			send_request(op, id);
		end

		// tail: back-to-back count changes on one key at full rate
		steady = 1'b1;
		if (!ledger.pick_held(target))
			target = 64'hc0ff_ee00_1234_5678;
		send_request(OP_REGISTER, target);
		send_request(OP_REGISTER, target);
		send_request(OP_UNREGISTER, target);
		send_request(OP_REGISTER, target);
		send_request(OP_REGISTER, target);
		send_request(OP_QUERY, target);
		in_valid <= 1'b0;

		// wait for everything owed, then give stray results a chance to show up
		while (ledger.owed.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (ledger.mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== refcounted_id_slot_allocator_core.f =====
+incdir+hdl
hdl/rcsa_pkg.sv
hdl/rcsa_ram.sv
hdl/rcsa_seq.sv
hdl/refcounted_id_slot_allocator_core.sv
tb/tb.sv
